>>> sv/mieu_pkg.sv
`timescale 1ns / 1ps
package mieu_pkg;
    localparam int XLEN = 32;
    localparam int NREGS = 32;
    localparam int RIDX_W = 5;
    localparam int FUNC_W = 6;
    localparam int IMM_W = 16;
    localparam int DCNT_W = 6;

    localparam logic [FUNC_W-1:0] F_SLL   = 6'd0;
    localparam logic [FUNC_W-1:0] F_SRL   = 6'd1;
    localparam logic [FUNC_W-1:0] F_SRA   = 6'd2;
    localparam logic [FUNC_W-1:0] F_SLLV  = 6'd3;
    localparam logic [FUNC_W-1:0] F_SRLV  = 6'd4;
    localparam logic [FUNC_W-1:0] F_SRAV  = 6'd5;
    localparam logic [FUNC_W-1:0] F_MOVN  = 6'd6;
    localparam logic [FUNC_W-1:0] F_MOVZ  = 6'd7;
    localparam logic [FUNC_W-1:0] F_MFHI  = 6'd8;
    localparam logic [FUNC_W-1:0] F_MTHI  = 6'd9;
    localparam logic [FUNC_W-1:0] F_MFLO  = 6'd10;
    localparam logic [FUNC_W-1:0] F_MTLO  = 6'd11;
    localparam logic [FUNC_W-1:0] F_MULT  = 6'd12;
    localparam logic [FUNC_W-1:0] F_MULTU = 6'd13;
    localparam logic [FUNC_W-1:0] F_DIV   = 6'd14;
    localparam logic [FUNC_W-1:0] F_DIVU  = 6'd15;
    localparam logic [FUNC_W-1:0] F_ADD   = 6'd16;
    localparam logic [FUNC_W-1:0] F_ADDU  = 6'd17;
    localparam logic [FUNC_W-1:0] F_SUB   = 6'd18;
    localparam logic [FUNC_W-1:0] F_SUBU  = 6'd19;
    localparam logic [FUNC_W-1:0] F_AND   = 6'd20;
    localparam logic [FUNC_W-1:0] F_OR    = 6'd21;
    localparam logic [FUNC_W-1:0] F_XOR   = 6'd22;
    localparam logic [FUNC_W-1:0] F_NOR   = 6'd23;
    localparam logic [FUNC_W-1:0] F_SLT   = 6'd24;
    localparam logic [FUNC_W-1:0] F_SLTU  = 6'd25;
    localparam logic [FUNC_W-1:0] F_ADDI  = 6'd26;
    localparam logic [FUNC_W-1:0] F_ADDIU = 6'd27;
    localparam logic [FUNC_W-1:0] F_SLTI  = 6'd28;
    localparam logic [FUNC_W-1:0] F_SLTIU = 6'd29;
    localparam logic [FUNC_W-1:0] F_ANDI  = 6'd30;
    localparam logic [FUNC_W-1:0] F_ORI   = 6'd31;
    localparam logic [FUNC_W-1:0] F_XORI  = 6'd32;
    localparam logic [FUNC_W-1:0] F_LUI   = 6'd33;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [RIDX_W-1:0] dest_reg;
        logic [RIDX_W-1:0] src_a_reg;
        logic [RIDX_W-1:0] src_b_reg;
        logic [RIDX_W-1:0] shift_amount;
        logic [IMM_W-1:0]  immediate;
    } t_in;

    typedef struct packed {
        logic              reg_written;
        logic [RIDX_W-1:0] written_reg;
        logic [XLEN-1:0]   written_value;
        logic [XLEN-1:0]   hi_value;
        logic [XLEN-1:0]   lo_value;
        logic              divide_by_zero;
        logic              signed_overflow;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_FIN, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture instruction
        logic exec;      // ALU/move ops and div by zero, commit
        logic mul;       // commit product
        logic div_start;
        logic div_step;
        logic div_fin;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
        logic div_last;
    } t_sts;
endpackage

>>> sv/mieu_if.sv
`timescale 1ns / 1ps
interface mieu_in_if;
    logic          valid;
    logic          ready;
    mieu_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mieu_out_if;
    logic           valid;
    logic           ready;
    mieu_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/mieu_ctrl.sv
`timescale 1ns / 1ps
module mieu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mieu_pkg::t_sts  i_sts,
    output mieu_pkg::t_cmd  o_cmd
);
    mieu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mieu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            mieu_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state = mieu_pkg::S_READ;
                end
            end
            mieu_pkg::S_READ: begin
                if (i_sts.is_mul) begin
                    n_state = mieu_pkg::S_MUL;
                end else if (i_sts.is_div && !i_sts.div_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state = mieu_pkg::S_DIV;
                end else begin
                    n_state = mieu_pkg::S_EXEC;
                end
            end
            mieu_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = mieu_pkg::S_OUT;
            end
            mieu_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = mieu_pkg::S_OUT;
            end
            mieu_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = mieu_pkg::S_FIN;
                end
            end
            mieu_pkg::S_FIN: begin
                o_cmd.div_fin = 1'b1;
                n_state = mieu_pkg::S_OUT;
            end
            mieu_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = mieu_pkg::S_READ;
                    end else begin
                        n_state = mieu_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = mieu_pkg::S_IDLE;
        endcase
    end

    a_load_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> o_in_ready)
        else $error("load without ready");
    a_div_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> r_state == mieu_pkg::S_DIV)
        else $error("div start lost");
    a_out_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec || o_cmd.mul || o_cmd.div_fin) |=> o_out_valid)
        else $error("no result after commit");
endmodule

>>> sv/mieu_dp.sv
`timescale 1ns / 1ps
module mieu_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mieu_pkg::t_in   i_in,
    input  mieu_pkg::t_cmd  i_cmd,
    output mieu_pkg::t_sts  o_sts,
    output mieu_pkg::t_out  o_out
);
    localparam int XLEN = mieu_pkg::XLEN;
    localparam int RIDX_W_L = mieu_pkg::RIDX_W;

    logic [XLEN-1:0] r_rf [mieu_pkg::NREGS];
    logic [mieu_pkg::NREGS-1:0] r_rf_vld;
    logic [XLEN-1:0] r_hi, r_lo, r_rs, r_rt;
    mieu_pkg::t_in r_ins;
    mieu_pkg::t_out r_out, n_out;
    logic [2*XLEN-1:0] r_prod;
    logic [XLEN-1:0] r_quo, r_rem, r_dvs;
    logic [mieu_pkg::DCNT_W-1:0] r_cnt;
    logic r_neg_q, r_neg_r;

    logic [XLEN-1:0] rf_a, rf_b, sext_imm, zext_imm, val, sum, diff;
    logic [XLEN:0] trial;
    logic [RIDX_W_L-1:0] shamt;
    logic wr, ovf, dz;
    logic is_mul, is_div, sgn_div, sgn_mul;
    logic [XLEN-1:0] abs_a, abs_b;
    logic [XLEN:0] mul_a, mul_b;
    logic [2*XLEN+1:0] mul_p;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_ins <= i_in;
    end

    assign rf_a = (r_ins.src_a_reg == '0 || !r_rf_vld[r_ins.src_a_reg]) ? '0
                  : r_rf[r_ins.src_a_reg];
    assign rf_b = (r_ins.src_b_reg == '0 || !r_rf_vld[r_ins.src_b_reg]) ? '0
                  : r_rf[r_ins.src_b_reg];

    assign is_mul = (r_ins.func == mieu_pkg::F_MULT) || (r_ins.func == mieu_pkg::F_MULTU);
    assign is_div = (r_ins.func == mieu_pkg::F_DIV) || (r_ins.func == mieu_pkg::F_DIVU);
    assign sgn_div = r_ins.func == mieu_pkg::F_DIV;
    assign sgn_mul = r_ins.func == mieu_pkg::F_MULT;
    assign abs_a = (sgn_div && rf_a[XLEN-1]) ? (XLEN)'(0) - rf_a : rf_a;
    assign abs_b = (sgn_div && rf_b[XLEN-1]) ? (XLEN)'(0) - rf_b : rf_b;

    assign o_sts.is_mul = is_mul;
    assign o_sts.is_div = is_div;
    assign o_sts.div_zero = rf_b == '0;
    assign o_sts.div_last = r_cnt == '0;

    // READ state latches operands; the register file read path ends here
    always_ff @(posedge i_clk) begin
        r_rs <= rf_a;
        r_rt <= rf_b;
    end

    // multiply: one 33x33 signed product covers mult and multu, registered
    assign mul_a = {sgn_mul & rf_a[XLEN-1], rf_a};
    assign mul_b = {sgn_mul & rf_b[XLEN-1], rf_b};
    assign mul_p = $signed(mul_a) * $signed(mul_b);
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[2*XLEN-1:0];
    end

    // restoring divider, one quotient bit a cycle
    assign trial = {r_rem, r_quo[XLEN-1]} - {1'b0, r_dvs};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= abs_a;
            r_rem <= '0;
            r_dvs <= abs_b;
            r_cnt <= mieu_pkg::DCNT_W'(XLEN - 1);
            r_neg_q <= sgn_div && (rf_a[XLEN-1] ^ rf_b[XLEN-1]);
            r_neg_r <= sgn_div && rf_a[XLEN-1];
        end else if (i_cmd.div_step) begin
            if (!trial[XLEN]) begin
                r_rem <= trial[XLEN-1:0];
                r_quo <= {r_quo[XLEN-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[XLEN-2:0], r_quo[XLEN-1]};
                r_quo <= {r_quo[XLEN-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign sext_imm = {{(XLEN-mieu_pkg::IMM_W){r_ins.immediate[mieu_pkg::IMM_W-1]}},
                       r_ins.immediate};
    assign zext_imm = {{(XLEN-mieu_pkg::IMM_W){1'b0}}, r_ins.immediate};
    assign shamt = (r_ins.func == mieu_pkg::F_SLL || r_ins.func == mieu_pkg::F_SRL ||
                    r_ins.func == mieu_pkg::F_SRA) ? r_ins.shift_amount : r_rs[RIDX_W_L-1:0];
    assign sum = r_rs + ((r_ins.func == mieu_pkg::F_ADDI ||
                          r_ins.func == mieu_pkg::F_ADDIU) ? sext_imm : r_rt);
    assign diff = r_rs - r_rt;

    always_comb begin
        wr = 1'b0;
        val = '0;
        ovf = 1'b0;
        dz = 1'b0;
        unique case (r_ins.func)
            mieu_pkg::F_SLL, mieu_pkg::F_SLLV: begin wr = 1'b1; val = r_rt << shamt; end
            mieu_pkg::F_SRL, mieu_pkg::F_SRLV: begin wr = 1'b1; val = r_rt >> shamt; end
            mieu_pkg::F_SRA, mieu_pkg::F_SRAV: begin
                wr = 1'b1; val = $unsigned($signed(r_rt) >>> shamt);
            end
            mieu_pkg::F_MOVN: begin wr = r_rt != '0; val = r_rs; end
            mieu_pkg::F_MOVZ: begin wr = r_rt == '0; val = r_rs; end
            mieu_pkg::F_MFHI: begin wr = 1'b1; val = r_hi; end
            mieu_pkg::F_MFLO: begin wr = 1'b1; val = r_lo; end
            mieu_pkg::F_DIV, mieu_pkg::F_DIVU: dz = r_rt == '0;
            mieu_pkg::F_ADD, mieu_pkg::F_ADDI: begin
                wr = 1'b1; val = sum;
                ovf = (r_rs[XLEN-1] == val[XLEN-1]) ? 1'b0 :
                      (r_ins.func == mieu_pkg::F_ADD ? r_rs[XLEN-1] == r_rt[XLEN-1]
                                                     : r_rs[XLEN-1] == sext_imm[XLEN-1]);
            end
            mieu_pkg::F_ADDU, mieu_pkg::F_ADDIU: begin wr = 1'b1; val = sum; end
            mieu_pkg::F_SUB: begin
                wr = 1'b1; val = diff;
                ovf = (r_rs[XLEN-1] ^ r_rt[XLEN-1]) & (r_rs[XLEN-1] ^ diff[XLEN-1]);
            end
            mieu_pkg::F_SUBU: begin wr = 1'b1; val = diff; end
            mieu_pkg::F_AND: begin wr = 1'b1; val = r_rs & r_rt; end
            mieu_pkg::F_OR:  begin wr = 1'b1; val = r_rs | r_rt; end
            mieu_pkg::F_XOR: begin wr = 1'b1; val = r_rs ^ r_rt; end
            mieu_pkg::F_NOR: begin wr = 1'b1; val = ~(r_rs | r_rt); end
            mieu_pkg::F_SLT: begin
                wr = 1'b1; val = XLEN'($signed(r_rs) < $signed(r_rt));
            end
            mieu_pkg::F_SLTU: begin wr = 1'b1; val = XLEN'(r_rs < r_rt); end
            mieu_pkg::F_SLTI: begin
                wr = 1'b1; val = XLEN'($signed(r_rs) < $signed(sext_imm));
            end
            mieu_pkg::F_SLTIU: begin wr = 1'b1; val = XLEN'(r_rs < sext_imm); end
            mieu_pkg::F_ANDI: begin wr = 1'b1; val = r_rs & zext_imm; end
            mieu_pkg::F_ORI:  begin wr = 1'b1; val = r_rs | zext_imm; end
            mieu_pkg::F_XORI: begin wr = 1'b1; val = r_rs ^ zext_imm; end
            mieu_pkg::F_LUI:  begin wr = 1'b1; val = {r_ins.immediate, {mieu_pkg::IMM_W{1'b0}}}; end
            default: ;
        endcase
        if (!wr || r_ins.dest_reg == '0) begin
            wr = 1'b0;
            val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
            r_rf_vld <= '0;
        end else begin
            if (i_cmd.exec) begin
                if (wr) begin
                    r_rf[r_ins.dest_reg] <= val;
                    r_rf_vld[r_ins.dest_reg] <= 1'b1;
                end
                if (r_ins.func == mieu_pkg::F_MTHI) r_hi <= r_rs;
                if (r_ins.func == mieu_pkg::F_MTLO) r_lo <= r_rs;
            end
            if (i_cmd.mul) begin
                r_hi <= r_prod[2*XLEN-1:XLEN];
                r_lo <= r_prod[XLEN-1:0];
            end
            if (i_cmd.div_fin) begin
                r_lo <= r_neg_q ? (XLEN)'(0) - r_quo : r_quo;
                r_hi <= r_neg_r ? (XLEN)'(0) - r_rem : r_rem;
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (i_cmd.exec) begin
            n_out.reg_written = wr;
            n_out.written_reg = wr ? r_ins.dest_reg : '0;
            n_out.written_value = val;
            n_out.divide_by_zero = dz;
            n_out.signed_overflow = ovf;
        end
    end

    // flags/writes latched at commit; HI/LO read live after commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec || i_cmd.mul || i_cmd.div_fin) r_out <= n_out;
    end

    assign o_out = '{reg_written: r_out.reg_written, written_reg: r_out.written_reg,
                     written_value: r_out.written_value, hi_value: r_hi, lo_value: r_lo,
                     divide_by_zero: r_out.divide_by_zero,
                     signed_overflow: r_out.signed_overflow};

    a_r0_never: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && r_ins.dest_reg == '0 |-> !wr)
        else $error("write to r0");
    a_div_zero_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && dz |=> $stable(r_hi) && $stable(r_lo))
        else $error("hi/lo changed on divide by zero");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !(dz && ovf))
        else $error("both flags");
endmodule

>>> sv/mips_integer_execute_unit_core.sv
`timescale 1ns / 1ps
// ALU, move and multiply ops (and div/divu by zero) go READ, then EXEC or MUL, then OUT;
// div/divu with a nonzero divisor go READ, DIV (restoring divider, 1 bit/cycle), FIN, OUT.
// One instruction at a time; next beat accepted as the result beat leaves.
// Reset (synchronous, active low) clears HI, LO and the register file valid bits,
// so all registers read zero.
module mips_integer_execute_unit_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mieu_in_if.sink         in_ch,
    mieu_out_if.source      out_ch
);
    mieu_pkg::t_cmd cmd;
    mieu_pkg::t_sts sts;

    mieu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mieu_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (out_ch.data)
    );
endmodule
